// File: hw/rtl/irqt_pkg.sv
package irqt_pkg;

  // default store geometry
  localparam int MAX_WIDTH_DEF  = 64;
  localparam int MAX_HEIGHT_DEF = 64;

  localparam int CH_W   = 8;
  localparam int PIX_W  = 3 * CH_W;
  localparam int CFG_W  = 7;
  localparam int TURN_W = 2;
  localparam int IDX_W  = 2;

  localparam logic [CFG_W-1:0]  FRAME_WIDTH_RST   = 7'd64;
  localparam logic [CFG_W-1:0]  FRAME_HEIGHT_RST  = 7'd64;
  localparam logic [TURN_W-1:0] QUARTER_TURNS_RST = 2'd1;

  typedef enum logic [IDX_W-1:0] {
    CFG_FRAME_WIDTH   = 2'd0,
    CFG_FRAME_HEIGHT  = 2'd1,
    CFG_QUARTER_TURNS = 2'd2
  } cfg_reg_t;

  typedef enum logic [TURN_W-1:0] {
    TURN_0 = 2'd0,
    TURN_1 = 2'd1,
    TURN_2 = 2'd2,
    TURN_3 = 2'd3
  } turn_t;

  // per-read side information that travels with the store read
  typedef struct packed {
    logic rd_ok;
    logic line_end;
    logic frame_end;
  } rd_tag_t;

endpackage

// File: hw/rtl/irqt_if.sv
interface irqt_in_if;
  logic                     valid;
  logic                     ready;
  logic [irqt_pkg::CH_W-1:0] in_red;
  logic [irqt_pkg::CH_W-1:0] in_green;
  logic [irqt_pkg::CH_W-1:0] in_blue;

  modport source (output valid, output in_red, output in_green, output in_blue,
                  input ready);
  modport sink   (input valid, input in_red, input in_green, input in_blue,
                  output ready);
endinterface

interface irqt_out_if;
  logic                     valid;
  logic                     ready;
  logic [irqt_pkg::CH_W-1:0] out_red;
  logic [irqt_pkg::CH_W-1:0] out_green;
  logic [irqt_pkg::CH_W-1:0] out_blue;
  logic                     line_end;
  logic                     frame_end;

  modport source (output valid, output out_red, output out_green, output out_blue,
                  output line_end, output frame_end, input ready);
  modport sink   (input valid, input out_red, input out_green, input out_blue,
                  input line_end, input frame_end, output ready);
endinterface

// File: hw/rtl/irqt_frame_store.sv
module irqt_frame_store #(
  parameter int AW = 13
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [irqt_pkg::PIX_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [AW-1:0]              rd_addr,
  output logic [irqt_pkg::PIX_W-1:0] rd_data,
  output logic                       busy
);

  localparam int DEPTH = 1 << AW;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } clr_state_t;

  clr_state_t                 state_r, state_nxt;
  logic [AW-1:0]              clr_addr_r, clr_addr_nxt;
  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [irqt_pkg::PIX_W-1:0] mem_wdata;
  logic [irqt_pkg::PIX_W-1:0] mem [DEPTH];
  logic [irqt_pkg::PIX_W-1:0] rd_data_r;

  // clearing sweep, one entry per cycle after reset
  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (&clr_addr_r) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        clr_addr_nxt = '0;
      end
      default: begin
        state_nxt    = ST_CLEAR;
        clr_addr_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  assign busy      = (state_r != ST_RUN);
  assign mem_we    = busy || wr_en;
  assign mem_waddr = busy ? clr_addr_r : wr_addr;
  assign mem_wdata = busy ? '0 : wr_data;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: hw/rtl/irqt_addr_gen.sv
module irqt_addr_gen #(
  parameter int MAX_WIDTH  = irqt_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = irqt_pkg::MAX_HEIGHT_DEF,
  parameter int ROW_W      = $clog2(MAX_HEIGHT),
  parameter int COL_W      = $clog2(MAX_WIDTH),
  parameter int AW         = 1 + ROW_W + COL_W
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic [irqt_pkg::CFG_W-1:0]  cfg_width,
  input  logic [irqt_pkg::CFG_W-1:0]  cfg_height,
  input  logic [irqt_pkg::TURN_W-1:0] cfg_turns,
  output logic [AW-1:0]               wr_addr,
  output logic [AW-1:0]               rd_addr,
  output irqt_pkg::rd_tag_t           tag
);

  localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int OC_W    = $clog2(MAX_DIM);
  localparam int DIM_W   = OC_W + 2;
  localparam int CMP_W   = (DIM_W > irqt_pkg::CFG_W) ? DIM_W : irqt_pkg::CFG_W;

  logic [ROW_W-1:0] in_row_r, in_row_nxt;
  logic [COL_W-1:0] in_col_r, in_col_nxt;
  logic [OC_W-1:0]  out_row_r, out_row_nxt;
  logic [OC_W-1:0]  out_col_r, out_col_nxt;
  logic             wbank_r, wbank_nxt;

  logic [CMP_W-1:0] wid_ext, hgt_ext;
  logic [DIM_W-1:0] w, h, ow, oh;
  logic [DIM_W-1:0] orow, ocol, sr, sc;
  logic             lend, fend, ilend, ifend;

  // size clamp: zero acts as one, above the store acts as the maximum
  always_comb begin
    wid_ext = CMP_W'(cfg_width);
    hgt_ext = CMP_W'(cfg_height);
    if (wid_ext == '0) begin
      w = DIM_W'(1);
    end else if (wid_ext > CMP_W'(MAX_WIDTH)) begin
      w = DIM_W'(MAX_WIDTH);
    end else begin
      w = DIM_W'(wid_ext);
    end
    if (hgt_ext == '0) begin
      h = DIM_W'(1);
    end else if (hgt_ext > CMP_W'(MAX_HEIGHT)) begin
      h = DIM_W'(MAX_HEIGHT);
    end else begin
      h = DIM_W'(hgt_ext);
    end
    ow = cfg_turns[0] ? h : w;
    oh = cfg_turns[0] ? w : h;
  end

  // source position; an underflow wraps high and fails the range check
  always_comb begin
    orow = DIM_W'(out_row_r);
    ocol = DIM_W'(out_col_r);
    case (cfg_turns)
      irqt_pkg::TURN_0: begin
        sr = orow;
        sc = ocol;
      end
      irqt_pkg::TURN_1: begin
        sr = h - 1'b1 - ocol;
        sc = orow;
      end
      irqt_pkg::TURN_2: begin
        sr = h - 1'b1 - orow;
        sc = w - 1'b1 - ocol;
      end
      default: begin
        sr = ocol;
        sc = w - 1'b1 - orow;
      end
    endcase
  end

  assign tag.rd_ok = (sr < DIM_W'(MAX_HEIGHT)) && (sc < DIM_W'(MAX_WIDTH));
  assign rd_addr   = {~wbank_r, sr[ROW_W-1:0], sc[COL_W-1:0]};
  assign wr_addr   = {wbank_r, in_row_r, in_col_r};

  assign lend          = ocol >= ow - 1'b1;
  assign fend          = lend && (orow >= oh - 1'b1);
  assign tag.line_end  = lend;
  assign tag.frame_end = fend;

  assign ilend = DIM_W'(in_col_r) >= w - 1'b1;
  assign ifend = ilend && (DIM_W'(in_row_r) >= h - 1'b1);

  always_comb begin
    out_row_nxt = out_row_r;
    out_col_nxt = out_col_r;
    in_row_nxt  = in_row_r;
    in_col_nxt  = in_col_r;
    wbank_nxt   = wbank_r;
    if (step) begin
      if (fend) begin
        out_row_nxt = '0;
        out_col_nxt = '0;
      end else if (lend) begin
        out_col_nxt = '0;
        out_row_nxt = out_row_r + 1'b1;
      end else begin
        out_col_nxt = out_col_r + 1'b1;
      end
      if (ifend) begin
        in_row_nxt = '0;
        in_col_nxt = '0;
        wbank_nxt  = ~wbank_r;
      end else if (ilend) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + 1'b1;
      end else begin
        in_col_nxt = in_col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_row_r  <= '0;
      in_col_r  <= '0;
      out_row_r <= '0;
      out_col_r <= '0;
      wbank_r   <= 1'b0;
    end else begin
      in_row_r  <= in_row_nxt;
      in_col_r  <= in_col_nxt;
      out_row_r <= out_row_nxt;
      out_col_r <= out_col_nxt;
      wbank_r   <= wbank_nxt;
    end
  end

endmodule

// File: hw/rtl/image_rotate_quarter_turns.sv
// Quarter-turn image rotator. RGB pixels come in raster order, one item per
// clock while in_ready is high; each is written into one bank of a two-bank
// frame store while one pixel of the previous frame is read from the other
// bank in the raster order of the frame turned clockwise quarter_turns
// times (odd turns swap width and height). Every accepted input item yields
// exactly one result item, so output frames trail input frames by one
// frame; the first frame after reset comes out as zeros. Sustained rate is
// one item per clock while the output is not held, set by the store's
// single write port and single read port, both used once per item; a result
// passes via the store's read register, then the output register; a full
// output register stops intake only when the read stage behind it is also
// held. After reset all 2^AW store entries (8192 at the default 64 x 64)
// are cleared one entry per clock, with in_ready low; configuration writes
// are taken throughout. Sizes of zero act as one and sizes above the store
// act as its maximum. Change configuration only while the block is idle.
module image_rotate_quarter_turns #(
  parameter int MAX_WIDTH  = irqt_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = irqt_pkg::MAX_HEIGHT_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  irqt_in_if.sink                    in_ch,
  irqt_out_if.source                 out_ch,
  input  logic                       cfg_we,
  input  logic [irqt_pkg::IDX_W-1:0] cfg_index,
  input  logic [irqt_pkg::CFG_W-1:0] cfg_data
);

  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int AW    = 1 + ROW_W + COL_W;

  // configuration registers
  logic [irqt_pkg::CFG_W-1:0]  frame_width_r;
  logic [irqt_pkg::CFG_W-1:0]  frame_height_r;
  logic [irqt_pkg::TURN_W-1:0] quarter_turns_r;

  // handshake and pipeline control
  logic in_fire;
  logic s1_move;
  logic store_busy;
  logic s1_valid_r, s1_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  irqt_pkg::rd_tag_t s1_tag_r;
  irqt_pkg::rd_tag_t rd_tag;

  // store connections
  logic [AW-1:0]              wr_addr;
  logic [AW-1:0]              rd_addr;
  logic [irqt_pkg::PIX_W-1:0] wr_pix;
  logic [irqt_pkg::PIX_W-1:0] rd_pix;

  // output register
  logic [irqt_pkg::PIX_W-1:0] out_pix_r;
  logic                       out_line_end_r;
  logic                       out_frame_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r   <= irqt_pkg::FRAME_WIDTH_RST;
      frame_height_r  <= irqt_pkg::FRAME_HEIGHT_RST;
      quarter_turns_r <= irqt_pkg::QUARTER_TURNS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        irqt_pkg::CFG_FRAME_WIDTH:   frame_width_r   <= cfg_data;
        irqt_pkg::CFG_FRAME_HEIGHT:  frame_height_r  <= cfg_data;
        irqt_pkg::CFG_QUARTER_TURNS: quarter_turns_r <= cfg_data[irqt_pkg::TURN_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // the read stage moves on once the output register is free or being taken;
  // intake stops while the read stage is held, since its data sits in the
  // store's read register and a new read would overwrite it
  assign s1_move     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !store_busy && (!s1_valid_r || s1_move);
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign wr_pix = {in_ch.in_red, in_ch.in_green, in_ch.in_blue};

  // counters, rotation and store addressing
  irqt_addr_gen #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .ROW_W      (ROW_W),
    .COL_W      (COL_W),
    .AW         (AW)
  ) u_addr_gen (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (in_fire),
    .cfg_width  (frame_width_r),
    .cfg_height (frame_height_r),
    .cfg_turns  (quarter_turns_r),
    .wr_addr    (wr_addr),
    .rd_addr    (rd_addr),
    .tag        (rd_tag)
  );

  // ping-pong store: read and write of one item always hit opposite banks,
  // and the last write into a bank lands before the first read from it after
  // the swap
  irqt_frame_store #(
    .AW (AW)
  ) u_frame_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_fire),
    .wr_addr (wr_addr),
    .wr_data (wr_pix),
    .rd_en   (in_fire),
    .rd_addr (rd_addr),
    .rd_data (rd_pix),
    .busy    (store_busy)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_move) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_tag_r <= rd_tag;
    end
    if (s1_move) begin
      // source outside the store reads as zero
      out_pix_r       <= s1_tag_r.rd_ok ? rd_pix : '0;
      out_line_end_r  <= s1_tag_r.line_end;
      out_frame_end_r <= s1_tag_r.frame_end;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_red   = out_pix_r[3*irqt_pkg::CH_W-1:2*irqt_pkg::CH_W];
  assign out_ch.out_green = out_pix_r[2*irqt_pkg::CH_W-1:irqt_pkg::CH_W];
  assign out_ch.out_blue  = out_pix_r[irqt_pkg::CH_W-1:0];
  assign out_ch.line_end  = out_line_end_r;
  assign out_ch.frame_end = out_frame_end_r;

  // an accepted item always lands in the read stage
  a_fire_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> s1_valid_r)
    else $error("accepted item did not reach the read stage");

  // no intake while the store is being cleared
  a_busy_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    store_busy |-> !in_ch.ready)
    else $error("input taken during clearing sweep");

  // a held read stage must block intake, or its store data is lost
  a_hold_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_move) |-> !in_ch.ready)
    else $error("input taken while read stage is held");

  // a frame always ends on the end of a row
  a_frame_on_line: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.frame_end) |-> out_ch.line_end)
    else $error("frame end without line end");

endmodule

// File: tb/image_rotate_quarter_turns_tb.sv
`timescale 1ns / 100ps

module image_rotate_quarter_turns_tb;
  import irqt_pkg::*;

  // store geometry of the instance under test (default parameters)
  localparam int STORE_W    = MAX_WIDTH_DEF;
  localparam int STORE_H    = MAX_HEIGHT_DEF;
  localparam int BANK_WORDS = STORE_W * STORE_H;

  localparam int DIRECTED_N   = 24;
  localparam int RANDOM_ITEMS = 950;
  // largest frame area the random part picks, keeps big sizes rare
  localparam int AREA_CAP     = 256;
  localparam int MAX_PRINTS   = 100;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    pixel_t pix;
    logic   line_end;
    logic   frame_end;
  } rot_result_t;

  // one row of the directed table: optional setting change, then one item
  typedef struct packed {
    logic              new_cfg;
    logic [CFG_W-1:0]  w;
    logic [CFG_W-1:0]  h;
    turn_t             turns;
    pixel_t            pix;
    logic              typed;
    rot_result_t       want;
  } dir_row_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  irqt_in_if  in_ch ();
  irqt_out_if out_ch ();

  image_rotate_quarter_turns dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------------
  // rotation predictor: own copy of both banks, counters and settings
  // ---------------------------------------------------------------------
  logic [PIX_W-1:0] frame_copy [BANK_WORDS * 2];
  logic             wr_bank;
  int               wr_row, wr_col;
  int               rd_row, rd_col;
  logic [CFG_W-1:0] width_reg, height_reg;
  turn_t            turns_reg;

  // rotated pixels still owed by the block, oldest first
  rot_result_t      results_due [$];

  int mismatch_count;
  int results_seen;
  int pixels_sent;

  // handshake pacing
  int tx_calm, rx_calm;
  int rx_gap;

  // typed expectation for the item currently on the input channel
  logic        typed_due;
  rot_result_t typed_result;

  rot_result_t predicted, got, want;

  // zero acts as one, anything past the store acts as the store size
  function automatic int clamp_dim(input logic [CFG_W-1:0] v, input int limit);
    if (v == '0) return 1;
    if (int'(v) > limit) return limit;
    return int'(v);
  endfunction

  task automatic reset_model();
    for (int i = 0; i < BANK_WORDS * 2; i++) frame_copy[i] = '0;
    wr_bank    = 1'b0;
    wr_row     = 0;
    wr_col     = 0;
    rd_row     = 0;
    rd_col     = 0;
    width_reg  = FRAME_WIDTH_RST;
    height_reg = FRAME_HEIGHT_RST;
    turns_reg  = turn_t'(QUARTER_TURNS_RST);
  endtask

  // one item in: read the turned pixel of the previous frame from the idle
  // bank, write the new pixel into the active bank, advance both positions
  function automatic rot_result_t rotate_step(input pixel_t p);
    rot_result_t res;
    int          w, h, ow, oh;
    int          src_r, src_c;
    logic        lend, fend;
    w  = clamp_dim(width_reg, STORE_W);
    h  = clamp_dim(height_reg, STORE_H);
    // odd turns swap the output frame's sides
    ow = turns_reg[0] ? h : w;
    oh = turns_reg[0] ? w : h;
    case (turns_reg)
      TURN_0: begin
        src_r = rd_row;
        src_c = rd_col;
      end
      TURN_1: begin
        src_r = h - 1 - rd_col;
        src_c = rd_row;
      end
      TURN_2: begin
        src_r = h - 1 - rd_row;
        src_c = w - 1 - rd_col;
      end
      default: begin
        src_r = rd_col;
        src_c = w - 1 - rd_row;
      end
    endcase
    // a source outside the store (after a shrink mid-frame) reads as zero
    res.pix = '0;
    if (src_r >= 0 && src_r < STORE_H && src_c >= 0 && src_c < STORE_W)
      res.pix = frame_copy[int'(!wr_bank) * BANK_WORDS + src_r * STORE_W + src_c];
    if (wr_row < STORE_H && wr_col < STORE_W)
      frame_copy[int'(wr_bank) * BANK_WORDS + wr_row * STORE_W + wr_col] = p;

    // output position, ">=" so an oversize counter closes on the next item
    lend = (rd_col >= ow - 1);
    fend = lend && (rd_row >= oh - 1);
    if (fend) begin
      rd_row = 0;
      rd_col = 0;
    end else if (lend) begin
      rd_col = 0;
      rd_row++;
    end else begin
      rd_col++;
    end

    // input position, banks swap after the last pixel of an input frame
    if (wr_col >= w - 1 && wr_row >= h - 1) begin
      wr_row  = 0;
      wr_col  = 0;
      wr_bank = ~wr_bank;
    end else if (wr_col >= w - 1) begin
      wr_col = 0;
      wr_row++;
    end else begin
      wr_col++;
    end

    res.line_end  = lend;
    res.frame_end = fend;
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic check_pixel(input rot_result_t g, input rot_result_t e, input int idx);
    if (g.pix.red !== e.pix.red)
      report_mismatch($sformatf("pixel %0d out_red %0h, expected %0h",
                                idx, g.pix.red, e.pix.red));
    if (g.pix.green !== e.pix.green)
      report_mismatch($sformatf("pixel %0d out_green %0h, expected %0h",
                                idx, g.pix.green, e.pix.green));
    if (g.pix.blue !== e.pix.blue)
      report_mismatch($sformatf("pixel %0d out_blue %0h, expected %0h",
                                idx, g.pix.blue, e.pix.blue));
    if (g.line_end !== e.line_end)
      report_mismatch($sformatf("pixel %0d line_end %b, expected %b",
                                idx, g.line_end, e.line_end));
    if (g.frame_end !== e.frame_end)
      report_mismatch($sformatf("pixel %0d frame_end %b, expected %b",
                                idx, g.frame_end, e.frame_end));
  endtask

  // mostly a random wait, now and then a run of back-to-back items
  function automatic int draw_gap(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) begin
      calm_left = $urandom_range(20, 80);
      return 0;
    end
    return $urandom_range(0, 15);
  endfunction

  // both channels are sampled on the rising edge only; the input side is
  // handled first so an expectation exists before its result could show
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        predicted = rotate_step('{in_ch.in_red, in_ch.in_green, in_ch.in_blue});
        // directed rows with a hand-typed result override the predictor
        results_due.push_back(typed_due ? typed_result : predicted);
      end
      if (out_ch.valid && out_ch.ready) begin
        got.pix.red   = out_ch.out_red;
        got.pix.green = out_ch.out_green;
        got.pix.blue  = out_ch.out_blue;
        got.line_end  = out_ch.line_end;
        got.frame_end = out_ch.frame_end;
        if (results_due.size() == 0) begin
          report_mismatch($sformatf("pixel %0d arrived with nothing expected", results_seen));
        end else begin
          want = results_due.pop_front();
          check_pixel(got, want, results_seen);
        end
        results_seen++;
        rx_gap = draw_gap(rx_calm);
      end
    end
  end

  // receiver back-pressure, changed on the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (rx_gap > 0) begin
      out_ch.ready <= 1'b0;
      rx_gap--;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------
  function automatic pixel_t rand_pixel();
    pixel_t p;
    p.red   = $urandom_range(0, 255);
    p.green = $urandom_range(0, 255);
    p.blue  = $urandom_range(0, 255);
    return p;
  endfunction

  // mostly small sides, sometimes zero, the maximum, or past the store
  function automatic logic [CFG_W-1:0] pick_dim();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return CFG_W'($urandom_range(65, 127));
      2:       return CFG_W'(64);
      3:       return CFG_W'($urandom_range(9, 63));
      default: return CFG_W'($urandom_range(1, 8));
    endcase
  endfunction

  // valid stays high between back-to-back items, drops only for a gap
  task automatic send_pixel(input pixel_t p, input logic typed, input rot_result_t exp_res);
    int gap;
    gap = draw_gap(tx_calm);
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid    <= 1'b1;
    in_ch.in_red   <= p.red;
    in_ch.in_green <= p.green;
    in_ch.in_blue  <= p.blue;
    typed_due      = typed;
    typed_result   = exp_res;
    pixels_sent++;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // settings change only once every owed pixel has come back
  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (results_due.size() != 0) @(negedge clk);
  endtask

  // writes all three registers on consecutive clocks
  task automatic apply_setting(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                               input logic [CFG_W-1:0] turn_word);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FRAME_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    width_reg = w;
    @(negedge clk);
    cfg_index <= CFG_FRAME_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    height_reg = h;
    @(negedge clk);
    cfg_index <= CFG_QUARTER_TURNS;
    cfg_data  <= turn_word;
    @(posedge clk);
    // only the low bits count, upper bits of the data are ignored
    turns_reg = turn_t'(turn_word[TURN_W-1:0]);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // a 1x1 frame closes both positions on every item, which lines the input
  // and output frames up again after a partial frame
  task automatic realign_frames();
    wait_drained();
    apply_setting(CFG_W'($urandom_range(0, 1)), CFG_W'($urandom_range(0, 1)),
                  CFG_W'($urandom_range(0, 3)));
    send_pixel(rand_pixel(), 1'b0, '0);
  endtask

  // directed rows: first item extremes land in the cleared store, so the
  // results right after reset are zeros; typed results only where obvious
  dir_row_t directed_rows [DIRECTED_N] = '{
    // reset setting 64x64, one turn: cleared bank reads zero, no row end yet
    '{1'b0, 7'd0,   7'd0, TURN_0, 24'h000000, 1'b1, 26'h0},
    '{1'b0, 7'd0,   7'd0, TURN_0, 24'hFFFFFF, 1'b1, 26'h0},
    '{1'b0, 7'd0,   7'd0, TURN_0, 24'h55AA33, 1'b1, 26'h0},
    '{1'b0, 7'd0,   7'd0, TURN_0, 24'hAA55CC, 1'b1, 26'h0},
    // zero sizes act as one: row and frame close on this item, still zero
    '{1'b1, 7'd0,   7'd0, TURN_0, 24'h123456, 1'b1, 26'h3},
    '{1'b0, 7'd0,   7'd0, TURN_0, 24'h00FF00, 1'b0, 26'h0},
    // width past the store acts as 64, half turn
    '{1'b1, 7'd127, 7'd2, TURN_2, 24'hC0FFEE, 1'b0, 26'h0},
    '{1'b0, 7'd0,   7'd0, TURN_0, 24'h800001, 1'b0, 26'h0},
    '{1'b0, 7'd0,   7'd0, TURN_0, 24'h7FFFFE, 1'b0, 26'h0},
    '{1'b0, 7'd0,   7'd0, TURN_0, 24'h010080, 1'b0, 26'h0},
    '{1'b0, 7'd0,   7'd0, TURN_0, 24'hFE7F01, 1'b0, 26'h0},
    // shrink while counters are past the new size, quarter turn
    '{1'b1, 7'd3,   7'd2, TURN_1, 24'h111111, 1'b0, 26'h0},
    '{1'b0, 7'd0,   7'd0, TURN_0, 24'h222222, 1'b0, 26'h0},
    '{1'b0, 7'd0,   7'd0, TURN_0, 24'h333333, 1'b0, 26'h0},
    '{1'b0, 7'd0,   7'd0, TURN_0, 24'h444444, 1'b0, 26'h0},
    '{1'b0, 7'd0,   7'd0, TURN_0, 24'h555555, 1'b0, 26'h0},
    '{1'b0, 7'd0,   7'd0, TURN_0, 24'h666666, 1'b0, 26'h0},
    '{1'b0, 7'd0,   7'd0, TURN_0, 24'h777777, 1'b0, 26'h0},
    '{1'b0, 7'd0,   7'd0, TURN_0, 24'h888888, 1'b0, 26'h0},
    '{1'b0, 7'd0,   7'd0, TURN_0, 24'h999999, 1'b0, 26'h0},
    '{1'b0, 7'd0,   7'd0, TURN_0, 24'hAAAAAA, 1'b0, 26'h0},
    '{1'b0, 7'd0,   7'd0, TURN_0, 24'hBBBBBB, 1'b0, 26'h0},
    '{1'b0, 7'd0,   7'd0, TURN_0, 24'hCCCCCC, 1'b0, 26'h0},
    // three quarter turns
    '{1'b1, 7'd2,   7'd3, TURN_3, 24'hDDDDDD, 1'b0, 26'h0}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case a handshake never completes
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [CFG_W-1:0] w_val, h_val, turn_word;
    int               ew, eh, area, n;
    bit               broken;

    // every block input known from time zero
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_FRAME_WIDTH;
    cfg_data       = '0;
    in_ch.valid    = 1'b0;
    in_ch.in_red   = '0;
    in_ch.in_green = '0;
    in_ch.in_blue  = '0;
    out_ch.ready   = 1'b0;
    typed_due      = 1'b0;
    typed_result   = '0;
    mismatch_count = 0;
    results_seen   = 0;
    pixels_sent    = 0;
    tx_calm        = 0;
    rx_calm        = 0;
    rx_gap         = 0;
    reset_model();

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // directed part; the block's store clear after reset simply holds off
    // the first handshake
    for (int i = 0; i < DIRECTED_N; i++) begin
      if (directed_rows[i].new_cfg) begin
        wait_drained();
        apply_setting(directed_rows[i].w, directed_rows[i].h,
                      CFG_W'(directed_rows[i].turns));
      end
      send_pixel(directed_rows[i].pix, directed_rows[i].typed, directed_rows[i].want);
    end

    // random part: mostly whole frames (at least two so a turned frame comes
    // back), now and then a partial frame followed by a realignment
    realign_frames();
    while (pixels_sent < DIRECTED_N + RANDOM_ITEMS) begin
      w_val = pick_dim();
      h_val = pick_dim();
      ew    = clamp_dim(w_val, STORE_W);
      eh    = clamp_dim(h_val, STORE_H);
      if (ew * eh > AREA_CAP) begin
        if (ew >= eh) h_val = CFG_W'($urandom_range(1, 4));
        else          w_val = CFG_W'($urandom_range(1, 4));
      end
      area = clamp_dim(w_val, STORE_W) * clamp_dim(h_val, STORE_H);

      turn_word = CFG_W'($urandom_range(0, 3));
      // upper data bits of the turn register must be ignored
      if ($urandom_range(0, 3) == 0)
        turn_word[CFG_W-1:TURN_W] = (CFG_W - TURN_W)'($urandom_range(0, 31));

      broken = ($urandom_range(0, 7) == 0);
      if (broken) n = $urandom_range(1, 2 * area);
      else        n = area * ((area > 64) ? 2 : $urandom_range(2, 4));

      wait_drained();
      apply_setting(w_val, h_val, turn_word);
      repeat (n) send_pixel(rand_pixel(), 1'b0, '0);
      if (broken) realign_frames();
    end

    // drain, then allow a few more clocks for any stray result
    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/irqt_pkg.sv
hw/rtl/irqt_if.sv
hw/rtl/irqt_frame_store.sv
hw/rtl/irqt_addr_gen.sv
hw/rtl/image_rotate_quarter_turns.sv
tb/image_rotate_quarter_turns_tb.sv
